// ----- design/odo_pkg.sv -----
// Shared types, constants and arithmetic helpers of the differential-drive odometry block.
// Depends on nothing; the multiplier, divider, CORDIC and top-level files refer to it by scoped names.
package odo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES     = 24;
  localparam int unsigned ATAN_IDX_W       = 5;

  localparam int unsigned MUL_OP_W = 34;
  localparam int unsigned MUL_P_W  = 2 * MUL_OP_W;
  localparam int unsigned DIV_N_W  = 50;
  localparam int unsigned DIV_D_W  = 16;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned CORDIC_W = 34;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_PER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_TRACK_WIDTH = 2'd1;

  localparam logic [31:0] DPC_RESET = 32'd2698608;
  localparam logic [23:0] ITW_RESET = 24'd546133;

  localparam logic [29:0] TURN_SCALE  = 30'd683565276;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [DIV_D_W-1:0] TRAP_DIVISOR = 16'd2000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_R, ST_DIV_R, ST_WAIT_R, ST_MUL_L, ST_DIV_L, ST_WAIT_L,
    ST_YAW_MUL, ST_YAW, ST_TH_MUL, ST_TH_DIV, ST_TH_WAIT, ST_ANG_MUL, ST_ANG,
    ST_COR1, ST_VX, ST_VY, ST_PX_DIV, ST_PX_WAIT, ST_PY_DIV, ST_PY_WAIT,
    ST_COR2, ST_OUT
  } state_t;

  // Arctangent of 2^-i as a binary angle, 2^32 units per turn.
  function automatic logic [31:0] atan_bam(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -68'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Round a Q4.30 value to Q2.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W:0] t;
    logic signed [CORDIC_W:0] r;
    logic signed [15:0] o;
    t = {v[CORDIC_W-1], v} + 35'sd32768;
    r = t >>> 16;
    if (r > 35'sd16384) o = 16'sd16384;
    else if (r < -35'sd16384) o = -16'sd16384;
    else o = r[15:0];
    return o;
  endfunction

endpackage

// ----- design/odo_if.sv -----
// Valid/ready channel interfaces for the odometry block's input and result transfers.
// Depends on nothing.
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] delta_time_ms;
  logic signed [15:0] delta_right_count;
  logic signed [15:0] delta_left_count;
  modport source (output valid, output delta_time_ms, output delta_right_count,
                  output delta_left_count, input ready);
  modport sink (input valid, input delta_time_ms, input delta_right_count,
                input delta_left_count, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic               time_error;
  modport source (output valid, output pos_x, output pos_y, output heading, output vel_x,
                  output vel_y, output yaw_rate, output quat_z, output quat_w,
                  output time_error, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading, input vel_x,
                input vel_y, input yaw_rate, input quat_z, input quat_w,
                input time_error, output ready);
endinterface

// ----- design/odo_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on odo_pkg for operand widths.
module odo_mul (
  input  logic                                clk,
  input  logic signed [odo_pkg::MUL_OP_W-1:0] a,
  input  logic signed [odo_pkg::MUL_OP_W-1:0] b,
  output logic signed [odo_pkg::MUL_P_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- design/odo_div.sv -----
// Unsigned restoring divider that retires two quotient bits per cycle.
// Depends on odo_pkg for dividend, divisor and counter widths.
module odo_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [odo_pkg::DIV_N_W-1:0]       dividend,
  input  logic [odo_pkg::DIV_D_W-1:0]       divisor,
  output logic                              busy_r,
  output logic [odo_pkg::DIV_N_W-1:0]       quotient
);

  localparam int unsigned NW = odo_pkg::DIV_N_W;
  localparam int unsigned DW = odo_pkg::DIV_D_W;
  localparam int unsigned CW = odo_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(NW / 2 - 1);

  logic [NW-1:0] n_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   r1, r2;
  logic          ge1, ge2;
  logic [DW-1:0] s1, s2;

  always_comb begin
    r1  = {rem_r, n_r[NW-1]};
    ge1 = (r1 >= {1'b0, d_r});
    s1  = ge1 ? DW'(r1 - {1'b0, d_r}) : r1[DW-1:0];
    r2  = {s1, n_r[NW-2]};
    ge2 = (r2 >= {1'b0, d_r});
    s2  = ge2 ? DW'(r2 - {1'b0, d_r}) : r2[DW-1:0];
  end

  assign quotient = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[NW-3:0], ge1, ge2};
      rem_r <= s2;
    end
  end

endmodule

// ----- design/odo_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q4.30.
// Depends on odo_pkg for the arctangent table, gain and widths.
module odo_cordic #(
  parameter int unsigned STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [31:0]                          angle,
  output logic                                 busy_r,
  output logic signed [odo_pkg::CORDIC_W-1:0]  cos_o,
  output logic signed [odo_pkg::CORDIC_W-1:0]  sin_o
);

  localparam int unsigned N  = (STEPS > odo_pkg::ATAN_ENTRIES) ? odo_pkg::ATAN_ENTRIES : STEPS;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned W  = odo_pkg::CORDIC_W;

  logic signed [W-1:0] x_r, y_r, z_r;
  logic [1:0]          q_r;
  logic [CW-1:0]       cnt_r;
  logic [1:0]          q_start;
  logic [31:0]         d_start;
  logic signed [W-1:0] dx, dy, at;

  always_comb begin
    q_start = 2'((angle + 32'h2000_0000) >> 30);
    d_start = angle - {q_start, 30'd0};
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = W'(odo_pkg::atan_bam(odo_pkg::ATAN_IDX_W'(cnt_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(N - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= odo_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= W'($signed(d_start));
      q_r <= q_start;
    end else if (busy_r) begin
      if (!z_r[W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  // Rotate the octant result back into the quadrant of the original angle.
  always_comb begin
    case (q_r)
      2'd0:    begin cos_o = x_r;  sin_o = y_r;  end
      2'd1:    begin cos_o = -y_r; sin_o = x_r;  end
      2'd2:    begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r;  sin_o = -x_r; end
    endcase
  end

endmodule

// ----- design/diff_drive_odometry.sv -----
// Differential-drive wheel odometry: top level with the step sequencer and state registers.
// Depends on odo_pkg, odo_if, odo_mul, odo_div and odo_cordic.
//
// The block takes one encoder sample at a time over in_if and returns one pose result over
// out_if for each. The next sample can be taken in the cycle after the result's transfer.
// The five long divisions (two wheel speeds and three trapezoid increments) each hold
// the sequencer while the shared two-bit-per-cycle divider iterates. The CORDIC runs twice,
// once for the velocity rotation and once for the heading quaternion. Fifteen further steps
// set up the shared multiplier and divider and present the result. CORDIC_STEPS counts at
// most 24 here. A sample with zero time keeps the stored state and flags time_error. The
// input is not ready while a sample is in progress or its result awaits transfer.
// Configuration writes over the cfg_ port take effect at once and must only be issued while
// the block is idle.
module diff_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [odo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  odo_in_if.sink                            in_if,
  odo_out_if.source                         out_if
);

  localparam int unsigned OW = odo_pkg::MUL_OP_W;
  localparam int unsigned PW = odo_pkg::MUL_P_W;
  localparam int unsigned NW = odo_pkg::DIV_N_W;
  localparam int unsigned CWD = odo_pkg::CORDIC_W;

  odo_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0] dpc_r;
  logic [23:0] itw_r;

  // Sample and working registers.
  logic [15:0]        t_r;
  logic signed [15:0] cr_r, cl_r;
  logic               err_r;
  logic signed [31:0] vr_r, vl_r, w_r, mean_r, vx_r, vy_r;
  logic [31:0]        ang2_r;
  logic               div_neg_r;

  // Odometry state.
  logic signed [31:0] heading_r, pos_x_r, pos_y_r, prev_vx_r, prev_vy_r, prev_w_r;
  logic signed [15:0] quat_z_r, quat_w_r;

  // Shared units.
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p_r;
  logic                 div_start, div_busy_r, div_neg;
  logic [NW-1:0]        div_n, div_q;
  logic [15:0]          div_d;
  logic                 cor_start, cor_busy_r;
  logic [31:0]          cor_angle;
  logic signed [CWD-1:0] cor_c, cor_s;

  odo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p_r));

  odo_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy_r(div_busy_r), .quotient(div_q)
  );

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(cor_angle),
    .busy_r(cor_busy_r), .cos_o(cor_c), .sin_o(cor_s)
  );

  // Derived values from the product register and the divider.
  logic [16:0]          cr_mag, cl_mag;
  logic [57:0]          wheel_num;
  logic [PW-1:0]        p_mag;
  logic signed [PW-1:0] q_signed;
  logic signed [PW-1:0] prod_sh16, prod_sh17, prod_sh30;
  logic [31:0]          ang1;

  always_comb begin
    cr_mag = cr_r[15] ? 17'(-{cr_r[15], cr_r}) : {1'b0, cr_r};
    cl_mag = cl_r[15] ? 17'(-{cl_r[15], cl_r}) : {1'b0, cl_r};
    // count * distance * 1000, scaled down by 2^16 before dividing by the time.
    wheel_num = ({10'd0, mul_p_r[47:0]} << 10) - ({10'd0, mul_p_r[47:0]} << 4)
              - ({10'd0, mul_p_r[47:0]} << 3);
    p_mag     = mul_p_r[PW-1] ? PW'(-mul_p_r) : PW'(mul_p_r);
    q_signed  = div_neg_r ? -$signed({{(PW-NW){1'b0}}, div_q})
                          : $signed({{(PW-NW){1'b0}}, div_q});
    prod_sh16 = mul_p_r >>> 16;
    prod_sh17 = mul_p_r >>> 17;
    prod_sh30 = mul_p_r >>> 30;
    ang1      = prod_sh16[31:0];
  end

  // Sequencer: next state and unit controls.
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = odo_pkg::TRAP_DIVISOR;
    div_neg   = 1'b0;
    cor_start = 1'b0;
    cor_angle = ang2_r;
    unique case (state_r)
      odo_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = (in_if.delta_time_ms == 16'd0) ? odo_pkg::ST_ANG_MUL : odo_pkg::ST_MUL_R;
        end
      end
      odo_pkg::ST_MUL_R: begin
        mul_a = OW'(cr_mag);
        mul_b = OW'(dpc_r);
        state_nxt = odo_pkg::ST_DIV_R;
      end
      odo_pkg::ST_DIV_R: begin
        div_start = 1'b1;
        div_n     = NW'(wheel_num >> 16);
        div_d     = t_r;
        div_neg   = cr_r[15];
        state_nxt = odo_pkg::ST_WAIT_R;
      end
      odo_pkg::ST_WAIT_R: begin
        if (!div_busy_r) state_nxt = odo_pkg::ST_MUL_L;
      end
      odo_pkg::ST_MUL_L: begin
        mul_a = OW'(cl_mag);
        mul_b = OW'(dpc_r);
        state_nxt = odo_pkg::ST_DIV_L;
      end
      odo_pkg::ST_DIV_L: begin
        div_start = 1'b1;
        div_n     = NW'(wheel_num >> 16);
        div_d     = t_r;
        div_neg   = cl_r[15];
        state_nxt = odo_pkg::ST_WAIT_L;
      end
      odo_pkg::ST_WAIT_L: begin
        if (!div_busy_r) state_nxt = odo_pkg::ST_YAW_MUL;
      end
      odo_pkg::ST_YAW_MUL: begin
        mul_a = OW'($signed({vr_r[31], vr_r} - {vl_r[31], vl_r}));
        mul_b = OW'(itw_r);
        state_nxt = odo_pkg::ST_YAW;
      end
      odo_pkg::ST_YAW: begin
        state_nxt = odo_pkg::ST_TH_MUL;
      end
      odo_pkg::ST_TH_MUL: begin
        mul_a = OW'(t_r);
        mul_b = OW'($signed({w_r[31], w_r} + {prev_w_r[31], prev_w_r}));
        state_nxt = odo_pkg::ST_TH_DIV;
      end
      odo_pkg::ST_TH_DIV, odo_pkg::ST_PX_DIV, odo_pkg::ST_PY_DIV: begin
        div_start = 1'b1;
        div_n     = p_mag[NW-1:0];
        div_neg   = mul_p_r[PW-1];
        case (state_r)
          odo_pkg::ST_TH_DIV: state_nxt = odo_pkg::ST_TH_WAIT;
          odo_pkg::ST_PX_DIV: state_nxt = odo_pkg::ST_PX_WAIT;
          default:            state_nxt = odo_pkg::ST_PY_WAIT;
        endcase
      end
      odo_pkg::ST_TH_WAIT: begin
        if (!div_busy_r) state_nxt = odo_pkg::ST_ANG_MUL;
      end
      odo_pkg::ST_ANG_MUL: begin
        mul_a = OW'(heading_r);
        mul_b = OW'(odo_pkg::TURN_SCALE);
        state_nxt = odo_pkg::ST_ANG;
      end
      odo_pkg::ST_ANG: begin
        // A zero-time sample only needs the quaternion of the stored heading.
        cor_start = 1'b1;
        cor_angle = err_r ? prod_sh17[31:0] : ang1;
        state_nxt = err_r ? odo_pkg::ST_COR2 : odo_pkg::ST_COR1;
      end
      odo_pkg::ST_COR1: begin
        mul_a = OW'(mean_r);
        mul_b = OW'(cor_c);
        if (!cor_busy_r) state_nxt = odo_pkg::ST_VX;
      end
      odo_pkg::ST_VX: begin
        mul_a = OW'(mean_r);
        mul_b = OW'(cor_s);
        state_nxt = odo_pkg::ST_VY;
      end
      odo_pkg::ST_VY: begin
        mul_a = OW'(t_r);
        mul_b = OW'($signed({vx_r[31], vx_r} + {prev_vx_r[31], prev_vx_r}));
        state_nxt = odo_pkg::ST_PX_DIV;
      end
      odo_pkg::ST_PX_WAIT: begin
        mul_a = OW'(t_r);
        mul_b = OW'($signed({vy_r[31], vy_r} + {prev_vy_r[31], prev_vy_r}));
        if (!div_busy_r) state_nxt = odo_pkg::ST_PY_DIV;
      end
      odo_pkg::ST_PY_WAIT: begin
        if (!div_busy_r) begin
          cor_start = 1'b1;
          state_nxt = odo_pkg::ST_COR2;
        end
      end
      odo_pkg::ST_COR2: begin
        if (!cor_busy_r) state_nxt = odo_pkg::ST_OUT;
      end
      odo_pkg::ST_OUT: begin
        if (out_if.ready) state_nxt = odo_pkg::ST_IDLE;
      end
      default: state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= odo_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration writes; indexes outside the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r <= odo_pkg::DPC_RESET;
      itw_r <= odo_pkg::ITW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        odo_pkg::CFG_DISTANCE_PER_COUNT:  dpc_r <= cfg_wdata;
        odo_pkg::CFG_INVERSE_TRACK_WIDTH: itw_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Odometry state, cleared by reset and updated as the sequence completes each quantity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      prev_vx_r <= '0;
      prev_vy_r <= '0;
      prev_w_r  <= '0;
    end else begin
      case (state_r)
        odo_pkg::ST_TH_WAIT:
          if (!div_busy_r) heading_r <= odo_pkg::sat32(PW'(heading_r) + q_signed);
        odo_pkg::ST_PX_WAIT:
          if (!div_busy_r) pos_x_r <= odo_pkg::sat32(PW'(pos_x_r) + q_signed);
        odo_pkg::ST_PY_WAIT:
          if (!div_busy_r) begin
            pos_y_r   <= odo_pkg::sat32(PW'(pos_y_r) + q_signed);
            prev_vx_r <= vx_r;
            prev_vy_r <= vy_r;
            prev_w_r  <= w_r;
          end
        default: ;
      endcase
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (div_start) div_neg_r <= div_neg;
    case (state_r)
      odo_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          t_r   <= in_if.delta_time_ms;
          cr_r  <= in_if.delta_right_count;
          cl_r  <= in_if.delta_left_count;
          err_r <= (in_if.delta_time_ms == 16'd0);
        end
      end
      odo_pkg::ST_WAIT_R: if (!div_busy_r) vr_r <= odo_pkg::sat32(q_signed);
      odo_pkg::ST_WAIT_L: if (!div_busy_r) vl_r <= odo_pkg::sat32(q_signed);
      odo_pkg::ST_YAW: begin
        w_r    <= odo_pkg::sat32(prod_sh16);
        mean_r <= 32'(({vl_r[31], vl_r} + {vr_r[31], vr_r}) >>> 1);
      end
      odo_pkg::ST_ANG:  ang2_r <= prod_sh17[31:0];
      odo_pkg::ST_VX:   vx_r   <= odo_pkg::sat32(prod_sh30);
      odo_pkg::ST_VY:   vy_r   <= odo_pkg::sat32(prod_sh30);
      odo_pkg::ST_COR2: begin
        if (!cor_busy_r) begin
          quat_z_r <= odo_pkg::to_q14(cor_s);
          quat_w_r <= odo_pkg::to_q14(cor_c);
        end
      end
      default: ;
    endcase
  end

  // The result is shown straight from the state registers, which hold still until transfer.
  assign in_if.ready       = (state_r == odo_pkg::ST_IDLE);
  assign out_if.valid      = (state_r == odo_pkg::ST_OUT);
  assign out_if.pos_x      = pos_x_r;
  assign out_if.pos_y      = pos_y_r;
  assign out_if.heading    = heading_r;
  assign out_if.vel_x      = prev_vx_r;
  assign out_if.vel_y      = prev_vy_r;
  assign out_if.yaw_rate   = prev_w_r;
  assign out_if.quat_z     = quat_z_r;
  assign out_if.quat_w     = quat_w_r;
  assign out_if.time_error = err_r;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the differential-drive odometry block.
// Depends on odo_pkg, odo_if and diff_drive_odometry from the design folder.
`timescale 1ns / 1ps

module tb_top;

  // A transfer with no progress for this many cycles ends the run. Receiver stalls are
  // short random runs.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned STEPS = odo_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               time_error;
  } pose_t;

  // Scoreboard: it carries its own copy of the odometry state and configuration,
  // computes the pose for each accepted sample and checks results in order.
  class odo_scoreboard;
    logic [31:0]        dist_per_count;
    logic [23:0]        inv_track;
    logic signed [31:0] head_acc, px_acc, py_acc, last_vx, last_vy, last_yaw;
    pose_t              pending_poses[$];
    int unsigned        mismatches;

    function new();
      dist_per_count = odo_pkg::DPC_RESET;
      inv_track      = odo_pkg::ITW_RESET;
      head_acc = 0; px_acc = 0; py_acc = 0;
      last_vx = 0; last_vy = 0; last_yaw = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [odo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx == odo_pkg::CFG_DISTANCE_PER_COUNT) dist_per_count = value;
      else if (idx == odo_pkg::CFG_INVERSE_TRACK_WIDTH) inv_track = value[23:0];
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Division rounding towards zero; the divisor is always positive.
    function longint div_trunc(longint n, longint d);
      return n / d;
    endfunction

    function logic signed [31:0] speed_of(longint count, longint t);
      longint num;
      num = count * longint'({32'd0, dist_per_count}) * 1000;
      return 32'(clip32(div_trunc(num, t * 65536)));
    endfunction

    function logic signed [31:0] integrate(logic signed [31:0] acc, logic signed [31:0] now,
                                           logic signed [31:0] prev, longint t);
      longint inc;
      inc = div_trunc(t * (longint'(now) + longint'(prev)), 2000);
      return 32'(clip32(longint'(acc) + inc));
    endfunction

    // Rotation-mode CORDIC on a binary angle of 2^32 units per turn, Q2.30 out.
    function void sin_cos(logic [31:0] angle, output longint c, output longint s);
      logic [31:0] quad, resid;
      longint x, y, z, dx, dy;
      quad  = (angle + 32'h2000_0000) >> 30;
      resid = angle - (quad << 30);
      z = longint'($signed(resid));
      x = longint'(odo_pkg::CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < STEPS && i < odo_pkg::ATAN_ENTRIES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(odo_pkg::atan_bam(odo_pkg::ATAN_IDX_W'(i)));
        end else begin
          x += dx; y -= dy; z += longint'(odo_pkg::atan_bam(odo_pkg::ATAN_IDX_W'(i)));
        end
      end
      case (quad[1:0])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic signed [15:0] q14_of(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
    endfunction

    function void note_sample(logic [15:0] t_ms, logic signed [15:0] cnt_r,
                              logic signed [15:0] cnt_l);
      longint t, c, s, prod;
      logic signed [31:0] vr, vl, w, mean, vx, vy;
      pose_t p;
      t = longint'({48'd0, t_ms});
      if (t != 0) begin
        vr = speed_of(longint'(cnt_r), t);
        vl = speed_of(longint'(cnt_l), t);
        w = 32'(clip32(((longint'(vr) - longint'(vl)) * longint'({40'd0, inv_track})) >>> 16));
        mean = 32'((longint'(vl) + longint'(vr)) >>> 1);
        head_acc = integrate(head_acc, w, last_yaw, t);
        prod = longint'(head_acc) * longint'(odo_pkg::TURN_SCALE);
        sin_cos(32'(prod >>> 16), c, s);
        vx = 32'(clip32((longint'(mean) * c) >>> 30));
        vy = 32'(clip32((longint'(mean) * s) >>> 30));
        px_acc = integrate(px_acc, vx, last_vx, t);
        py_acc = integrate(py_acc, vy, last_vy, t);
        last_vx = vx; last_vy = vy; last_yaw = w;
      end
      // The quaternion uses half the stored heading, whether or not it moved.
      prod = longint'(head_acc) * longint'(odo_pkg::TURN_SCALE);
      sin_cos(32'(prod >>> 17), c, s);
      p.pos_x = px_acc; p.pos_y = py_acc; p.heading = head_acc;
      p.vel_x = last_vx; p.vel_y = last_vy; p.yaw_rate = last_yaw;
      p.quat_z = q14_of(s); p.quat_w = q14_of(c);
      p.time_error = (t == 0);
      pending_poses.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("Result transfer with no sample pending");
        return;
      end
      want = pending_poses.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Pose mismatch: expected x=%0d y=%0d h=%0d vx=%0d vy=%0d w=%0d qz=%0d qw=%0d e=%0b, got x=%0d y=%0d h=%0d vx=%0d vy=%0d w=%0d qz=%0d qw=%0d e=%0b",
                   want.pos_x, want.pos_y, want.heading, want.vel_x, want.vel_y,
                   want.yaw_rate, want.quat_z, want.quat_w, want.time_error,
                   got.pos_x, got.pos_y, got.heading, got.vel_x, got.vel_y,
                   got.yaw_rate, got.quat_z, got.quat_w, got.time_error);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [odo_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [odo_pkg::CFG_DATA_W-1:0] cfg_wdata;

  odo_in_if  in_if ();
  odo_out_if out_if ();

  diff_drive_odometry u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  odo_scoreboard sb = new();
  bit            no_idle;
  int unsigned   quiet_cycles;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // The receiver stalls at random, changing ready only on the falling edge.
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 27);
  end

  // Results are taken at the rising edge, where both handshake lines are stable.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_pose(pose_t'({out_if.pos_x, out_if.pos_y, out_if.heading, out_if.vel_x,
                             out_if.vel_y, out_if.yaw_rate, out_if.quat_z, out_if.quat_w,
                             out_if.time_error}));
  end

  // Watchdog: a run in which no transfer happens for too long has hung.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Presents one sample after a random number of idle cycles and holds it until the
  // transfer. Valid stays high between back-to-back samples.
  task automatic send_sample(logic [15:0] t_ms, logic signed [15:0] cnt_r,
                             logic signed [15:0] cnt_l);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.delta_time_ms = t_ms;
    in_if.delta_right_count = cnt_r;
    in_if.delta_left_count = cnt_l;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(t_ms, cnt_r, cnt_l);
  endtask

  // Lowers valid and waits until every pending pose has been transferred, so that
  // the block is idle.
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [odo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Random sample: most have realistic times and counts, the rest span every bit.
  task automatic send_random();
    logic [15:0] t_ms;
    logic [15:0] cr, cl;
    if ($urandom_range(99) < 70) begin
      t_ms = 16'($urandom_range(50, 1));
      cr = 16'($urandom_range(400) - 200);
      cl = 16'($urandom_range(400) - 200);
    end else begin
      t_ms = 16'($urandom);
      cr = 16'($urandom);
      cl = 16'($urandom);
    end
    if ($urandom_range(99) < 3) t_ms = 16'd0;
    send_sample(t_ms, $signed(cr), $signed(cl));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.delta_time_ms = '0; in_if.delta_right_count = '0; in_if.delta_left_count = '0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset configuration: zero time on a fresh state, then the
    // extremes of time and counts, straight and turning motion.
    send_sample(16'd0, 16'sd100, -16'sd100);
    send_sample(16'd10, 16'sd100, 16'sd100);
    send_sample(16'd10, 16'sd50, -16'sd50);
    send_sample(16'd0, 16'sd7, 16'sd9);
    send_sample(16'd1, 16'sd32767, -16'sd32768);
    send_sample(16'd1, -16'sd32768, 16'sd32767);
    send_sample(16'd65535, 16'sd32767, 16'sd32767);
    send_sample(16'd65535, -16'sd32768, -16'sd32768);
    send_sample(16'd20, 16'sd0, 16'sd0);
    send_sample(16'd5, -16'sd1, 16'sd1);
    drain();

    // Largest travel and track reciprocal: speeds saturate and the heading is driven
    // into saturation in both directions, so the trigonometry sees large angles.
    write_reg(odo_pkg::CFG_DISTANCE_PER_COUNT, 32'hffff_ffff);
    write_reg(odo_pkg::CFG_INVERSE_TRACK_WIDTH, 32'h00ff_ffff);
    repeat (4) send_sample(16'd65535, 16'sd32767, -16'sd32768);
    send_sample(16'd0, 16'sd1, 16'sd1);
    repeat (4) send_sample(16'd65535, -16'sd32768, 16'sd32767);
    send_sample(16'd3, 16'sd1000, 16'sd900);
    drain();

    // Zero registers: no motion at all, whatever the counts.
    write_reg(odo_pkg::CFG_DISTANCE_PER_COUNT, 32'd0);
    write_reg(odo_pkg::CFG_INVERSE_TRACK_WIDTH, 32'd0);
    send_sample(16'd1, 16'sd32767, -16'sd32768);
    send_sample(16'd100, -16'sd300, 16'sd200);
    drain();

    // Random part in six phases of different settings. The third phase runs with no
    // idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(odo_pkg::CFG_DISTANCE_PER_COUNT, odo_pkg::DPC_RESET);
          write_reg(odo_pkg::CFG_INVERSE_TRACK_WIDTH, odo_pkg::ITW_RESET);
        end
        1: begin
          write_reg(odo_pkg::CFG_DISTANCE_PER_COUNT, 32'hffff_ffff);
          write_reg(odo_pkg::CFG_INVERSE_TRACK_WIDTH, 32'h00ff_ffff);
        end
        5: begin
          write_reg(odo_pkg::CFG_DISTANCE_PER_COUNT, 32'd1);
          write_reg(odo_pkg::CFG_INVERSE_TRACK_WIDTH, 32'd1);
        end
        default: begin
          write_reg(odo_pkg::CFG_DISTANCE_PER_COUNT, $urandom);
          write_reg(odo_pkg::CFG_INVERSE_TRACK_WIDTH, $urandom_range(24'hff_ffff));
        end
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        send_random();
        // Halfway through each phase the sender holds off until every pose has come back.
        if (n == 50) drain();
      end
      drain();
      no_idle = 1'b0;
    end

    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_poses.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
